// ----- src/lses_pkg.sv -----
// Package for the LED strip effect sequencer: types, codes, colors and the color wheel.
package lses_pkg;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_SWEEP
    } lses_state_t;

    // Effect codes
    localparam logic [3:0] EFF_BLACK          = 4'd0;
    localparam logic [3:0] EFF_BLINK_WHITE    = 4'd1;
    localparam logic [3:0] EFF_BLINK_RED      = 4'd2;
    localparam logic [3:0] EFF_BLINK_GREEN    = 4'd3;
    localparam logic [3:0] EFF_BLINK_BLUE     = 4'd4;
    localparam logic [3:0] EFF_BLINK_YELLOW   = 4'd5;
    localparam logic [3:0] EFF_HORIZONTAL     = 4'd6;
    localparam logic [3:0] EFF_SNAKE          = 4'd7;
    localparam logic [3:0] EFF_RAINBOW        = 4'd8;
    localparam logic [3:0] EFF_RAINBOW_CYCLE  = 4'd9;
    localparam logic [3:0] EFF_CHASE          = 4'd10;
    localparam logic [3:0] EFF_CHASE_RAINBOW  = 4'd11;

    // Configuration register indexes
    localparam logic [0:0] REG_EFFECT_SELECT  = 1'd0;
    localparam logic [0:0] REG_PANEL_ON       = 1'd1;

    localparam int COLOR_W = 24;
    typedef logic [COLOR_W-1:0] color_t;   // {red, green, blue}

    localparam color_t COLOR_BLACK  = 24'h000000;
    localparam color_t COLOR_WHITE  = 24'hFFFFFF;
    localparam color_t COLOR_RED    = 24'hFF0000;
    localparam color_t COLOR_GREEN  = 24'h00FF00;
    localparam color_t COLOR_BLUE   = 24'h0000FF;
    localparam color_t COLOR_YELLOW = 24'hFFFF00;

    localparam logic [13:0] MS_MAX = 14'h3FFF;

    // Color wheel: red -> green -> blue -> red over 256 positions
    function automatic color_t wheel(input logic [7:0] pos);
        logic [7:0] p;
        logic [7:0] d;
        logic [7:0] up;
        logic [7:0] down;
        color_t     c;
        p = ~pos;
        if (p < 8'd85) begin
            d = p;
        end else if (p < 8'd170) begin
            d = p - 8'd85;
        end else begin
            d = p - 8'd170;
        end
        up   = 8'(10'(d) * 10'd3);
        down = 8'd255 - up;
        if (p < 8'd85) begin
            c = {down, 8'd0, up};
        end else if (p < 8'd170) begin
            c = {8'd0, up, down};
        end else begin
            c = {up, down, 8'd0};
        end
        return c;
    endfunction

    // Blink colors by effect code
    function automatic color_t blink_color(input logic [3:0] code);
        color_t c;
        case (code)
            EFF_BLINK_WHITE:  c = COLOR_WHITE;
            EFF_BLINK_RED:    c = COLOR_RED;
            EFF_BLINK_GREEN:  c = COLOR_GREEN;
            EFF_BLINK_BLUE:   c = COLOR_BLUE;
            EFF_BLINK_YELLOW: c = COLOR_YELLOW;
            default:          c = COLOR_BLACK;
        endcase
        return c;
    endfunction

endpackage

// ----- src/led_strip_effect_sequencer.sv -----
// LED strip effect sequencer: step timer, per-pixel renderer and frame output stream.
//
// Input stream (s_*): one transfer carries ms_elapsed, milliseconds of time.
// The milliseconds accumulate (saturating at 16383); when the sum exceeds the
// step period of the current effect the step counter advances and a frame of
// NUM_PIXELS pixels is rendered and streamed out on m_*, pixel 0 first, with
// m_tlast on the last pixel. A transfer that does not cross the period gives
// no output.
// A stepping transfer first passes through the step update; then, while the
// receiver keeps up, one pixel per cycle goes through the shared renderer and
// the frame store port. m_tvalid rises for the first pixel after the step
// state, the first sweep fire and the render register; s_tready returns
// once the last pixel has been issued into the two-stage output path.
// m_tready low stalls the sweep in place; nothing is dropped.
// Configuration: cfg_wr_en with cfg_index 0 writes effect_select (clears the
// step counter, loads limit and period for the defined effect codes), index 1
// writes panel_on. Write only while the block is idle and the output stream is drained.
// Reset (aresetn low, synchronous): effect 1, panel off, step limit 1, period
// 10 ms, all pixels black (per-pixel valid bits, no clearing pass).
module led_strip_effect_sequencer
    import lses_pkg::*;
#(
    parameter int NUM_PIXELS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] ms_elapsed
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,      // [5:0] pixel_index, [13:6] red, [21:14] green,
                                      // [29:22] blue, [31:30] zero
    output logic        m_tlast,      // last_pixel
    // configuration
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [3:0]  cfg_wr_data
);

    localparam int IDX_W    = $clog2(NUM_PIXELS);
    localparam int REM_W    = IDX_W + 1;
    localparam int QSTEP    = 256 / NUM_PIXELS;
    localparam int RSTEP    = 256 % NUM_PIXELS;
    localparam int LAST_IDX = NUM_PIXELS - 1;

    // control state
    lses_state_t  state_reg, state_next;
    logic [13:0]  ms_reg, ms_next;
    logic [9:0]   cnt_reg, cnt_next;
    logic [1:0]   smod3_reg, smod3_next;     // step count mod 3
    logic [9:0]   limit_reg, limit_next;
    logic [13:0]  period_reg, period_next;
    logic [3:0]   effect_reg, effect_next;
    logic         panel_reg, panel_next;

    // sweep counters
    logic [IDX_W-1:0] p_reg, p_next;
    logic [1:0]       pm3_reg, pm3_next;     // pixel index mod 3
    logic [7:0]       pq_reg, pq_next;       // pixel * 256 / NUM_PIXELS
    logic [REM_W-1:0] rem_reg, rem_next;

    // render stage and output register
    logic             b_valid_reg;
    logic [IDX_W-1:0] b_idx_reg;
    logic             b_write_reg;
    color_t           b_color_reg;
    logic             b_last_reg;
    logic             m_tvalid_reg;
    logic [IDX_W-1:0] m_idx_reg;
    color_t           m_color_reg;
    logic             m_last_reg;
    logic [NUM_PIXELS-1:0] valid_reg;

    logic [14:0]  ms_sum;
    logic [13:0]  ms_sat;
    logic         step_hit;
    logic [9:0]   cnt_inc;
    logic [REM_W:0] rem_sum;
    logic         out_free;
    logic         a_fire;
    logic         b_move;
    logic         p_last;
    logic [1:0]   rmod3;
    logic [8:0]   chase_sum;
    logic [7:0]   chase_pos;
    logic [7:0]   wheel_pos;
    color_t       wheel_rgb;
    logic         a_write;
    color_t       a_color;
    color_t       ram_rd_data;
    color_t       b_pixel;

    // handshake helpers
    assign out_free = !m_tvalid_reg || m_tready;
    assign a_fire   = (state_reg == ST_SWEEP) && (!b_valid_reg || out_free);
    assign b_move   = b_valid_reg && out_free;
    assign p_last   = (p_reg == IDX_W'(LAST_IDX));
    assign s_tready = (state_reg == ST_IDLE);

    // elapsed time accumulation
    assign ms_sum   = 15'(ms_reg) + 15'(s_tdata);
    assign ms_sat   = ms_sum[14] ? MS_MAX : ms_sum[13:0];
    assign step_hit = (ms_sat > period_reg);
    assign cnt_inc  = cnt_reg + 10'd1;
    assign rem_sum  = (REM_W+1)'(rem_reg) + (REM_W+1)'(RSTEP);

    // sequencer and register writes
    always_comb begin
        state_next  = state_reg;
        ms_next     = ms_reg;
        cnt_next    = cnt_reg;
        smod3_next  = smod3_reg;
        limit_next  = limit_reg;
        period_next = period_reg;
        effect_next = effect_reg;
        panel_next  = panel_reg;
        p_next      = p_reg;
        pm3_next    = pm3_reg;
        pq_next     = pq_reg;
        rem_next    = rem_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (step_hit) begin
                        ms_next    = '0;
                        state_next = ST_STEP;
                    end else begin
                        ms_next = ms_sat;
                    end
                end
            end
            ST_STEP: begin
                if (cnt_inc >= limit_reg || cnt_inc == 10'd0) begin
                    cnt_next   = '0;
                    smod3_next = 2'd0;
                end else begin
                    cnt_next   = cnt_inc;
                    smod3_next = (smod3_reg == 2'd2) ? 2'd0 : smod3_reg + 2'd1;
                end
                p_next     = '0;
                pm3_next   = 2'd0;
                pq_next    = 8'd0;
                rem_next   = '0;
                state_next = ST_SWEEP;
            end
            ST_SWEEP: begin
                if (a_fire) begin
                    p_next   = p_reg + IDX_W'(1);
                    pm3_next = (pm3_reg == 2'd2) ? 2'd0 : pm3_reg + 2'd1;
                    if (rem_sum >= (REM_W+1)'(NUM_PIXELS)) begin
                        rem_next = REM_W'(rem_sum - (REM_W+1)'(NUM_PIXELS));
                        pq_next  = pq_reg + 8'(QSTEP) + 8'd1;
                    end else begin
                        rem_next = REM_W'(rem_sum);
                        pq_next  = pq_reg + 8'(QSTEP);
                    end
                    if (p_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // configuration writes
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_EFFECT_SELECT: begin
                    effect_next = cfg_wr_data;
                    cnt_next    = '0;
                    smod3_next  = 2'd0;
                    unique case (cfg_wr_data) inside
                        EFF_BLACK: begin
                            limit_next = 10'd1;   period_next = 14'd10000;
                        end
                        [EFF_BLINK_WHITE:EFF_BLINK_YELLOW]: begin
                            limit_next = 10'd12;  period_next = 14'd4;
                        end
                        EFF_HORIZONTAL: begin
                            limit_next = 10'd5;   period_next = 14'd200;
                        end
                        EFF_SNAKE: begin
                            limit_next = 10'(NUM_PIXELS); period_next = 14'd100;
                        end
                        EFF_RAINBOW, EFF_RAINBOW_CYCLE: begin
                            limit_next = 10'd256; period_next = 14'd10;
                        end
                        EFF_CHASE: begin
                            limit_next = 10'd3;   period_next = 14'd100;
                        end
                        EFF_CHASE_RAINBOW: begin
                            limit_next = 10'd768; period_next = 14'd80;
                        end
                        default: ;               // unused codes keep limit and period
                    endcase
                end
                REG_PANEL_ON: panel_next = cfg_wr_data[0];
            endcase
        end
    end

    // shared color unit: wheel position select
    assign rmod3     = (smod3_reg == 2'd2) ? 2'd0 : smod3_reg + 2'd1;
    assign chase_sum = 9'(p_reg) - 9'(smod3_reg) + 9'(cnt_reg[7:0]);
    assign chase_pos = (chase_sum >= 9'd255) ? 8'(chase_sum - 9'd255) : chase_sum[7:0];

    always_comb begin
        case (effect_reg)
            EFF_RAINBOW:       wheel_pos = 8'(p_reg) + cnt_reg[7:0];
            EFF_RAINBOW_CYCLE: wheel_pos = pq_reg + cnt_reg[7:0];
            default:           wheel_pos = chase_pos;
        endcase
    end

    assign wheel_rgb = wheel(wheel_pos);

    // per-pixel render decision
    always_comb begin
        a_write = 1'b1;
        a_color = COLOR_BLACK;
        if (panel_reg) begin
            unique case (effect_reg) inside
                EFF_BLACK: a_color = COLOR_BLACK;
                [EFF_BLINK_WHITE:EFF_BLINK_YELLOW]:
                    a_color = (cnt_reg == 10'd0) ? blink_color(effect_reg) : COLOR_BLACK;
                EFF_HORIZONTAL:
                    a_color = (10'(p_reg >> 2) == cnt_reg) ? COLOR_WHITE : COLOR_BLACK;
                EFF_SNAKE:
                    a_color = (10'(p_reg) == cnt_reg) ? COLOR_WHITE : COLOR_BLACK;
                EFF_RAINBOW, EFF_RAINBOW_CYCLE:
                    a_color = wheel_rgb;
                EFF_CHASE: begin
                    if (pm3_reg == rmod3) begin
                        a_color = COLOR_BLACK;
                    end else if (pm3_reg == smod3_reg) begin
                        a_color = COLOR_WHITE;
                    end else begin
                        a_write = 1'b0;
                    end
                end
                EFF_CHASE_RAINBOW: begin
                    if (pm3_reg == rmod3) begin
                        a_color = COLOR_BLACK;
                    end else if (pm3_reg == smod3_reg) begin
                        a_color = wheel_rgb;
                    end else begin
                        a_write = 1'b0;
                    end
                end
                default: a_write = 1'b0;   // unused code: frame unchanged
            endcase
        end
    end

    // frame store
    lses_ram #(
        .WIDTH(COLOR_W),
        .DEPTH(NUM_PIXELS)
    ) u_frame_ram (
        .aclk    (aclk),
        .wr_en   (b_move && b_write_reg),
        .wr_addr (b_idx_reg),
        .wr_data (b_color_reg),
        .rd_en   (a_fire),
        .rd_addr (p_reg),
        .rd_data (ram_rd_data)
    );

    // new color, stored color, or black for a never-written pixel
    assign b_pixel = b_write_reg ? b_color_reg :
                     (valid_reg[b_idx_reg] ? ram_rd_data : COLOR_BLACK);

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ms_reg       <= '0;
            cnt_reg      <= '0;
            smod3_reg    <= 2'd0;
            limit_reg    <= 10'd1;
            period_reg   <= 14'd10;
            effect_reg   <= EFF_BLINK_WHITE;
            panel_reg    <= 1'b0;
            b_valid_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            valid_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            ms_reg     <= ms_next;
            cnt_reg    <= cnt_next;
            smod3_reg  <= smod3_next;
            limit_reg  <= limit_next;
            period_reg <= period_next;
            effect_reg <= effect_next;
            panel_reg  <= panel_next;
            if (a_fire) begin
                b_valid_reg <= 1'b1;
            end else if (b_move) begin
                b_valid_reg <= 1'b0;
            end
            if (b_move) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (b_move && b_write_reg) begin
                valid_reg[b_idx_reg] <= 1'b1;
            end
        end
    end

    // sweep counters and payload registers
    always_ff @(posedge aclk) begin
        p_reg   <= p_next;
        pm3_reg <= pm3_next;
        pq_reg  <= pq_next;
        rem_reg <= rem_next;
        if (a_fire) begin
            b_idx_reg   <= p_reg;
            b_write_reg <= a_write;
            b_color_reg <= a_color;
            b_last_reg  <= p_last;
        end
        if (b_move) begin
            m_idx_reg   <= b_idx_reg;
            m_color_reg <= b_pixel;
            m_last_reg  <= b_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {2'b00, m_color_reg[7:0], m_color_reg[15:8], m_color_reg[23:16],
                       6'(m_idx_reg)};

`ifndef SYNTHESIS
    // step counter stays below its limit unless parked at zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 10'd0) || (cnt_reg < limit_reg))
        else $error("step counter at or past limit");

    // mod-3 trackers stay in range; the pixel one is loaded on each step
    assert property (@(posedge aclk) disable iff (!aresetn)
        (smod3_reg != 2'd3) && ((state_reg != ST_SWEEP) || (pm3_reg != 2'd3)))
        else $error("mod-3 tracker out of range");

    // frame end marker only on the last pixel
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_last_reg) |-> (m_idx_reg == IDX_W'(LAST_IDX)))
        else $error("tlast on wrong pixel");

    // a transfer that crosses the period starts a step
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && step_hit && !cfg_wr_en) |=> (state_reg == ST_STEP))
        else $error("step not started");
`endif

endmodule

// ----- src/lses_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lses_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // read port, holds while rd_en is low
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
